/* src/rv32_pkg.sv */
// Shared types and constants for the RV32I executor.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rv32_pkg;

  localparam int unsigned MemBytes  = 65536;
  localparam int unsigned DataWidth = 32;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_PC_MIS   = 3'd1,
    CAUSE_ILLEGAL  = 3'd2,
    CAUSE_ILL_CSR  = 3'd3,
    CAUSE_EBREAK   = 3'd4,
    CAUSE_ECALL    = 3'd5
  } cause_e;

  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6f;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [31:0] InsnEcall  = 32'h0000_0073;
  localparam logic [31:0] InsnEbreak = 32'h0010_0073;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] mem_address;
    logic [31:0] write_word;
  } in_item_t;

  typedef struct packed {
    logic [31:0] program_counter;
    logic        halted;
    logic [2:0]  halt_cause;
    logic [31:0] read_word;
    logic [31:0] retired_count;
    logic        dest_valid;
    logic [4:0]  dest_index;
    logic [31:0] dest_value;
  } out_item_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic       load_cmd;    // capture input item
    logic       hart_reset;  // clear pc, regs, count, halt
    logic       mem_rd;      // read byte at address selected by addr_data
    logic [1:0] byte_idx;    // byte lane within word
    logic       addr_data;   // 0: cmd/pc address, 1: data address
    logic       capture;     // store read byte into word buffer
    logic       mem_wr;      // write one byte
    logic       wr_cmd;      // write source is command word
    logic       decode;      // latch insn, read register file
    logic       execute;     // compute result, count retire
    logic       commit;      // update pc/regs/halt
    logic       check_pc;    // misaligned pc halt
    logic       emit;        // latch read word for the result
  } ctl_t;

  // Datapath -> controller status
  typedef struct packed {
    cmd_e       cmd;
    logic       halted;
    logic       pc_mis;
    logic       is_load;
    logic       is_store;
    logic       halts;     // decoded insn halts
    logic [2:0] nbytes_m1; // data access size minus one
  } sts_t;

endpackage
`default_nettype wire

/* src/rv32i_instruction_executor_unit.sv */
// RV32I executor: one command per item, byte-wide internal memory.
// Time to the done strobe depends on the command; a word load instruction takes
// longest. The memory port moves one byte per cycle.
// Next item can be accepted in the done cycle; the receiver cannot stall.
// Async reset clears pc, registers, count and halt state; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module rv32i_instruction_executor_unit #(
  parameter int unsigned MEM_BYTES = rv32_pkg::MemBytes
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire rv32_pkg::in_item_t  item_i,
  output logic                     done,
  output rv32_pkg::out_item_t      result_o
);
  import rv32_pkg::*;

  ctl_t      ctl;
  sts_t      sts;
  out_item_t res;
  logic      done_w;

  rv32_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .done_o(done_w),
    .sts_i(sts), .ctl_o(ctl)
  );

  rv32_datapath #(.MEM_BYTES(MEM_BYTES)) u_dp (
    .clk_i, .rst_ni, .item_i, .ctl_i(ctl), .sts_o(sts), .result_o(res)
  );

  assign done     = done_w;
  assign result_o = res;

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !$past(start && !busy)) else $error("done right after accept");
  a_halt_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !result_o.halted |-> result_o.halt_cause == CAUSE_NONE)
    else $error("cause without halt");
  a_dest_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && result_o.dest_valid |-> result_o.dest_index != 5'd0)
    else $error("x0 reported written");
endmodule
`default_nettype wire

/* src/rv32_datapath.sv */
// Datapath of the RV32I executor: registers, byte memory, decode and ALU.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rv32_datapath #(
  parameter int unsigned MEM_BYTES = rv32_pkg::MemBytes
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire rv32_pkg::in_item_t item_i,
  input  wire rv32_pkg::ctl_t     ctl_i,
  output rv32_pkg::sts_t          sts_o,
  output rv32_pkg::out_item_t     result_o
);
  import rv32_pkg::*;

  localparam int unsigned AW = $clog2(MEM_BYTES);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  rdata_q;
  logic        rinb_q;
  logic [1:0]  rlane_q; // byte lane of the read in flight

  in_item_t    cmd_q;
  logic [31:0] pc_q, pc_d, cnt_q, cnt_d;
  logic        halt_q, halt_d;
  logic [2:0]  cause_q, cause_d;
  logic [31:0] rf_q [32];
  logic [31:0] insn_q, a_q, b_q, word_q, val_q, next_q, daddr_q;
  logic        wen_q;
  logic        dv_q;
  logic [4:0]  di_q;
  logic [31:0] dval_q;
  logic [31:0] rword_q;

  logic [31:0] maddr, wsrc, byte_addr;
  logic [7:0]  wbyte;
  logic        inb;

  assign maddr = ctl_i.addr_data ? daddr_q :
                 ((cmd_q.opcode == CMD_EXEC) ? pc_q : {16'd0, cmd_q.mem_address});
  assign byte_addr = maddr + {30'd0, ctl_i.byte_idx};
  assign inb = (byte_addr < 32'(MEM_BYTES));
  assign wsrc = ctl_i.wr_cmd ? cmd_q.write_word : b_q;
  assign wbyte = wsrc[8*ctl_i.byte_idx +: 8];

  always_ff @(posedge clk_i) begin
    if (ctl_i.mem_wr && inb) begin
      mem[byte_addr[AW-1:0]] <= wbyte;
    end
    if (ctl_i.mem_rd) begin
      rdata_q <= mem[byte_addr[AW-1:0]];
      rinb_q  <= inb;
      rlane_q <= ctl_i.byte_idx;
    end
  end

  // decode fields
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  assign op = insn_q[6:0];
  assign rd = insn_q[11:7];
  assign f3 = insn_q[14:12];
  assign f7 = insn_q[31:25];
  assign imm_i = {{20{insn_q[31]}}, insn_q[31:20]};
  assign imm_s = {{20{insn_q[31]}}, insn_q[31:25], insn_q[11:7]};
  assign imm_b = {{19{insn_q[31]}}, insn_q[31], insn_q[7], insn_q[30:25], insn_q[11:8], 1'b0};
  assign imm_j = {{11{insn_q[31]}}, insn_q[31], insn_q[19:12], insn_q[20], insn_q[30:21], 1'b0};
  assign imm_u = {insn_q[31:12], 12'd0};

  logic       ill;
  logic [2:0] hcause;
  always_comb begin
    ill = 1'b0;
    hcause = CAUSE_NONE;
    unique case (op)
      OP_LUI, OP_AUIPC, OP_JAL: ill = 1'b0;
      OP_JALR:   ill = (f3 != 3'd0);
      OP_BRANCH: ill = (f3 == 3'd2) || (f3 == 3'd3);
      OP_LOAD:   ill = (f3 == 3'd3) || (f3 == 3'd6) || (f3 == 3'd7);
      OP_STORE:  ill = (f3 > 3'd2);
      OP_IMM:    ill = ((f3 == 3'd1) && (f7 != 7'd0)) ||
                       ((f3 == 3'd5) && (f7 != 7'd0) && (f7 != 7'h20));
      OP_REG:    ill = (f7 != 7'd0) && !((f7 == 7'h20) && ((f3 == 3'd0) || (f3 == 3'd5)));
      OP_SYSTEM: ill = 1'b0;
      default:   ill = 1'b1;
    endcase
    if (op == OP_SYSTEM) begin
      if (insn_q == InsnEcall) hcause = CAUSE_ECALL;
      else if (insn_q == InsnEbreak) hcause = CAUSE_EBREAK;
      else if ((f3 == 3'd0) || (f3 == 3'd4)) hcause = CAUSE_ILLEGAL;
      else hcause = CAUSE_ILL_CSR;
    end else if (ill) begin
      hcause = CAUSE_ILLEGAL;
    end
  end

  // ALU
  logic [31:0] opb, alu, nxt, pc4, lval;
  logic [4:0]  sh;
  logic        take, lts, ltu;
  assign opb = (op == OP_REG) ? b_q : imm_i;
  assign sh  = opb[4:0];
  assign lts = $signed(a_q) < $signed(opb);
  assign ltu = a_q < opb;
  assign pc4 = pc_q + 32'd4;

  always_comb begin
    unique case (f3)
      3'd0: alu = ((op == OP_REG) && f7[5]) ? a_q - opb : a_q + opb;
      3'd1: alu = a_q << sh;
      3'd2: alu = {31'd0, lts};
      3'd3: alu = {31'd0, ltu};
      3'd4: alu = a_q ^ opb;
      3'd5: alu = f7[5] ? 32'($signed(a_q) >>> sh) : a_q >> sh;
      3'd6: alu = a_q | opb;
      default: alu = a_q & opb;
    endcase
    unique case (f3)
      3'd0: take = (a_q == b_q);
      3'd1: take = (a_q != b_q);
      3'd4: take = $signed(a_q) < $signed(b_q);
      3'd5: take = !($signed(a_q) < $signed(b_q));
      3'd6: take = a_q < b_q;
      default: take = a_q >= b_q;
    endcase
  end

  always_comb begin
    unique case (f3)
      3'd0: lval = {{24{word_q[7]}}, word_q[7:0]};
      3'd1: lval = {{16{word_q[15]}}, word_q[15:0]};
      3'd4: lval = {24'd0, word_q[7:0]};
      3'd5: lval = {16'd0, word_q[15:0]};
      default: lval = word_q;
    endcase
  end

  always_comb begin
    nxt = pc4;
    unique case (op)
      OP_JAL:    nxt = pc_q + imm_j;
      OP_JALR:   nxt = (a_q + imm_i) & ~32'd1;
      OP_BRANCH: nxt = take ? pc_q + imm_b : pc4;
      default:   nxt = pc4;
    endcase
  end

  logic [2:0] nbytes_m1;
  always_comb begin
    unique case (f3)
      3'd0, 3'd4: nbytes_m1 = 3'd0;
      3'd1, 3'd5: nbytes_m1 = 3'd1;
      default:    nbytes_m1 = 3'd3;
    endcase
  end
  assign sts_o.nbytes_m1 = nbytes_m1;
  assign sts_o.cmd      = cmd_e'(cmd_q.opcode);
  assign sts_o.halted   = halt_q;
  assign sts_o.pc_mis   = (pc_q[1:0] != 2'd0);
  assign sts_o.halts    = (hcause != CAUSE_NONE);
  assign sts_o.is_load  = (op == OP_LOAD);
  assign sts_o.is_store = (op == OP_STORE);

  always_comb begin
    pc_d = pc_q; cnt_d = cnt_q; halt_d = halt_q; cause_d = cause_q;
    if (ctl_i.hart_reset) begin
      pc_d = '0; cnt_d = '0; halt_d = 1'b0; cause_d = CAUSE_NONE;
    end else if (ctl_i.check_pc) begin
      halt_d = 1'b1; cause_d = CAUSE_PC_MIS;
    end else begin
      if (ctl_i.execute) cnt_d = cnt_q + 32'd1;
      if (ctl_i.commit) begin
        if (hcause != CAUSE_NONE) begin
          halt_d = 1'b1; cause_d = hcause;
        end else begin
          pc_d = next_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0; cnt_q <= '0; halt_q <= 1'b0; cause_q <= CAUSE_NONE;
      dv_q <= 1'b0;
      for (int i = 0; i < 32; i++) rf_q[i] <= '0;
    end else begin
      pc_q <= pc_d; cnt_q <= cnt_d; halt_q <= halt_d; cause_q <= cause_d;
      if (ctl_i.load_cmd) dv_q <= 1'b0;
      if (ctl_i.hart_reset) begin
        for (int i = 0; i < 32; i++) rf_q[i] <= '0;
      end else if (ctl_i.commit && (hcause == CAUSE_NONE) && wen_q && (rd != 5'd0)) begin
        rf_q[rd] <= sts_o.is_load ? lval : val_q;
        dv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_cmd) begin
      cmd_q   <= item_i;
      word_q  <= '0;
      rword_q <= '0;
    end
    if (ctl_i.capture) begin
      word_q[8*rlane_q +: 8] <= rinb_q ? rdata_q : 8'd0;
    end
    if (ctl_i.decode) begin
      insn_q <= word_q;
      a_q    <= rf_q[word_q[19:15]];
      b_q    <= rf_q[word_q[24:20]];
    end
    if (ctl_i.execute) begin
      next_q  <= nxt;
      daddr_q <= a_q + ((op == OP_STORE) ? imm_s : imm_i);
      wen_q   <= (op != OP_BRANCH) && (op != OP_STORE);
      word_q  <= '0;
      unique case (op)
        OP_LUI:           val_q <= imm_u;
        OP_AUIPC:         val_q <= pc_q + imm_u;
        OP_JAL, OP_JALR:  val_q <= pc4;
        default:          val_q <= alu;
      endcase
    end
    if (ctl_i.commit) begin
      di_q   <= rd;
      dval_q <= sts_o.is_load ? lval : val_q;
    end
    if (ctl_i.emit && (cmd_q.opcode == CMD_READ)) rword_q <= word_q;
  end

  assign result_o.program_counter = pc_q;
  assign result_o.halted          = halt_q;
  assign result_o.halt_cause      = cause_q;
  assign result_o.read_word       = rword_q;
  assign result_o.retired_count   = cnt_q;
  assign result_o.dest_valid      = dv_q;
  assign result_o.dest_index      = dv_q ? di_q : 5'd0;
  assign result_o.dest_value      = dv_q ? dval_q : 32'd0;
endmodule
`default_nettype wire

/* src/rv32_ctrl.sv */
// Controller state machine of the RV32I executor; sequences byte accesses.
// Depends on rv32_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rv32_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  output logic                done_o,
  input  wire rv32_pkg::sts_t sts_i,
  output rv32_pkg::ctl_t      ctl_o
);
  import rv32_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_DISP   = 10'b0000000010,
    S_FETCH  = 10'b0000000100,
    S_DEC    = 10'b0000001000,
    S_EXE    = 10'b0000010000,
    S_DATA   = 10'b0000100000,
    S_COMMIT = 10'b0001000000,
    S_WRMEM  = 10'b0010000000,
    S_RDMEM  = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] idx_q, idx_d;
  logic       rdp_q, rdp_d; // read issued last cycle, capture pending

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    rdp_d   = 1'b0;
    ctl_o   = '0;
    ctl_o.byte_idx = idx_q;
    ctl_o.wr_cmd = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctl_o.load_cmd = 1'b1;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        idx_d = 2'd0;
        unique case (sts_i.cmd)
          CMD_WRITE: state_d = S_WRMEM;
          CMD_READ:  state_d = S_RDMEM;
          CMD_RESET: begin ctl_o.hart_reset = 1'b1; state_d = S_EMIT; end
          default: begin
            if (sts_i.halted) state_d = S_EMIT;
            else if (sts_i.pc_mis) begin ctl_o.check_pc = 1'b1; state_d = S_EMIT; end
            else state_d = S_FETCH;
          end
        endcase
      end
      S_WRMEM: begin
        ctl_o.mem_wr = 1'b1;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd3) state_d = S_EMIT;
      end
      S_RDMEM, S_FETCH: begin
        // one byte read per cycle, captured the cycle after
        if (rdp_q) ctl_o.capture = 1'b1;
        if (rdp_q && idx_q == 2'd0) begin
          state_d = (state_q == S_FETCH) ? S_DEC : S_EMIT;
        end else begin
          ctl_o.mem_rd = 1'b1;
          rdp_d = 1'b1;
          idx_d = idx_q + 2'd1;
        end
      end
      S_DEC: begin
        ctl_o.decode = 1'b1;
        state_d = S_EXE;
      end
      S_EXE: begin
        ctl_o.execute = 1'b1;
        idx_d = 2'd0;
        state_d = (!sts_i.halts && (sts_i.is_load || sts_i.is_store)) ? S_DATA : S_COMMIT;
      end
      S_DATA: begin
        ctl_o.addr_data = 1'b1;
        ctl_o.wr_cmd = 1'b0;
        if (sts_i.is_store) begin
          ctl_o.mem_wr = 1'b1;
          idx_d = idx_q + 2'd1;
          if ({1'b0, idx_q} == sts_i.nbytes_m1) state_d = S_COMMIT;
        end else begin
          if (rdp_q) ctl_o.capture = 1'b1;
          if (rdp_q && ({1'b0, idx_q - 2'd1} == sts_i.nbytes_m1)) begin
            state_d = S_COMMIT;
          end else begin
            ctl_o.mem_rd = 1'b1;
            rdp_d = 1'b1;
            idx_d = idx_q + 2'd1;
          end
        end
      end
      S_COMMIT: begin
        ctl_o.commit = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        ctl_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      rdp_q   <= 1'b0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      rdp_q   <= rdp_d;
      done_o  <= (state_q == S_EMIT);
    end
  end

  assign busy_o = (state_q != S_IDLE);
endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for rv32i_instruction_executor_unit: memory load, directed
// instructions, then random programs, each result checked against a hart predictor.
// Depends on rv32_pkg and the executor unit.
`timescale 1ns / 1ps

class hart_scoreboard;
  logic [31:0] pc;
  logic [31:0] regs [32];
  logic [7:0]  mem [rv32_pkg::MemBytes];
  bit          written [rv32_pkg::MemBytes];
  logic [31:0] retired;
  logic        halted;
  rv32_pkg::cause_e cause;
  rv32_pkg::out_item_t pending_results [$];
  int errors, n_write, n_read, n_exec, n_reset, n_halt;

  function void hart_clear();
    pc = '0;
    foreach (regs[i]) regs[i] = '0;
    retired = '0;
    halted = 1'b0;
    cause = rv32_pkg::CAUSE_NONE;
  endfunction

  // true when every in-range byte of the access has been written
  function bit bytes_known(logic [31:0] addr, int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      a = addr + i;
      if (a < rv32_pkg::MemBytes && !written[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function logic [31:0] get_bytes(logic [31:0] addr, int n);
    logic [31:0] v, a;
    v = '0;
    for (int i = 0; i < n; i++) begin
      a = addr + i;
      if (a < rv32_pkg::MemBytes) v[8*i +: 8] = mem[a];
    end
    return v;
  endfunction

  function void put_bytes(logic [31:0] addr, logic [31:0] v, int n);
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      a = addr + i;
      if (a < rv32_pkg::MemBytes) begin
        mem[a] = v[8*i +: 8];
        written[a] = 1'b1;
      end
    end
  endfunction

  function void stop_hart(rv32_pkg::cause_e c);
    halted = 1'b1;
    cause = c;
    n_halt++;
  endfunction

  function void retire_insn(logic [31:0] insn, output bit wrote,
                            output logic [4:0] rd, output logic [31:0] val);
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, nxt, addr;
    bit take;
    op = insn[6:0];
    rd = insn[11:7];
    f3 = insn[14:12];
    f7 = insn[31:25];
    a = regs[insn[19:15]];
    b = regs[insn[24:20]];
    imm_i = {{20{insn[31]}}, insn[31:20]};
    imm_s = {{20{insn[31]}}, insn[31:25], insn[11:7]};
    imm_b = {{19{insn[31]}}, insn[31], insn[7], insn[30:25], insn[11:8], 1'b0};
    imm_j = {{11{insn[31]}}, insn[31], insn[19:12], insn[20], insn[30:21], 1'b0};
    nxt = pc + 4;
    val = '0;
    wrote = 1'b0;
    case (op)
      rv32_pkg::OP_LUI:   val = {insn[31:12], 12'b0};
      rv32_pkg::OP_AUIPC: val = pc + {insn[31:12], 12'b0};
      rv32_pkg::OP_JAL: begin
        val = pc + 4;
        nxt = pc + imm_j;
      end
      rv32_pkg::OP_JALR: begin
        if (f3 != 0) begin
          stop_hart(rv32_pkg::CAUSE_ILLEGAL);
          return;
        end
        val = pc + 4;
        nxt = (a + imm_i) & ~32'd1;
      end
      rv32_pkg::OP_BRANCH: begin
        case (f3)
          3'd0: take = a == b;
          3'd1: take = a != b;
          3'd4: take = $signed(a) < $signed(b);
          3'd5: take = !($signed(a) < $signed(b));
          3'd6: take = a < b;
          3'd7: take = a >= b;
          default: begin
            stop_hart(rv32_pkg::CAUSE_ILLEGAL);
            return;
          end
        endcase
        pc = take ? pc + imm_b : nxt;
        return;
      end
      rv32_pkg::OP_LOAD: begin
        addr = a + imm_i;
        case (f3)
          3'd0: begin val = get_bytes(addr, 1); val = {{24{val[7]}}, val[7:0]}; end
          3'd1: begin val = get_bytes(addr, 2); val = {{16{val[15]}}, val[15:0]}; end
          3'd2: val = get_bytes(addr, 4);
          3'd4: val = get_bytes(addr, 1);
          3'd5: val = get_bytes(addr, 2);
          default: begin
            stop_hart(rv32_pkg::CAUSE_ILLEGAL);
            return;
          end
        endcase
      end
      rv32_pkg::OP_STORE: begin
        addr = a + imm_s;
        if (f3 > 3'd2) begin
          stop_hart(rv32_pkg::CAUSE_ILLEGAL);
          return;
        end
        put_bytes(addr, b, 1 << f3);
        pc = nxt;
        return;
      end
      rv32_pkg::OP_IMM: begin
        case (f3)
          3'd0: val = a + imm_i;
          3'd2: val = ($signed(a) < $signed(imm_i)) ? 32'd1 : 32'd0;
          3'd3: val = (a < imm_i) ? 32'd1 : 32'd0;
          3'd4: val = a ^ imm_i;
          3'd6: val = a | imm_i;
          3'd7: val = a & imm_i;
          3'd1: begin
            if (f7 != 0) begin
              stop_hart(rv32_pkg::CAUSE_ILLEGAL);
              return;
            end
            val = a << imm_i[4:0];
          end
          default: begin
            if (f7 == 7'h00) val = a >> imm_i[4:0];
            else if (f7 == 7'h20) val = $signed(a) >>> imm_i[4:0];
            else begin
              stop_hart(rv32_pkg::CAUSE_ILLEGAL);
              return;
            end
          end
        endcase
      end
      rv32_pkg::OP_REG: begin
        if (f7 == 7'h20 && f3 == 3'd0) val = a - b;
        else if (f7 == 7'h20 && f3 == 3'd5) val = $signed(a) >>> b[4:0];
        else if (f7 != 0) begin
          stop_hart(rv32_pkg::CAUSE_ILLEGAL);
          return;
        end else begin
          case (f3)
            3'd0: val = a + b;
            3'd1: val = a << b[4:0];
            3'd2: val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
            3'd3: val = (a < b) ? 32'd1 : 32'd0;
            3'd4: val = a ^ b;
            3'd5: val = a >> b[4:0];
            3'd6: val = a | b;
            default: val = a & b;
          endcase
        end
      end
      rv32_pkg::OP_SYSTEM: begin
        if (insn == rv32_pkg::InsnEcall) stop_hart(rv32_pkg::CAUSE_ECALL);
        else if (insn == rv32_pkg::InsnEbreak) stop_hart(rv32_pkg::CAUSE_EBREAK);
        else if (f3 == 3'd0 || f3 == 3'd4) stop_hart(rv32_pkg::CAUSE_ILLEGAL);
        else stop_hart(rv32_pkg::CAUSE_ILL_CSR);
        return;
      end
      default: begin
        stop_hart(rv32_pkg::CAUSE_ILLEGAL);
        return;
      end
    endcase
    pc = nxt;
    if (rd != 0) begin
      regs[rd] = val;
      wrote = 1'b1;
    end
  endfunction

  function void note_command(rv32_pkg::in_item_t it);
    rv32_pkg::out_item_t e;
    bit wrote;
    logic [4:0] rd;
    logic [31:0] val;
    e = '0;
    wrote = 1'b0;
    rd = '0;
    val = '0;
    case (rv32_pkg::cmd_e'(it.opcode))
      rv32_pkg::CMD_WRITE: begin
        put_bytes({16'b0, it.mem_address}, it.write_word, 4);
        n_write++;
      end
      rv32_pkg::CMD_READ: begin
        e.read_word = get_bytes({16'b0, it.mem_address}, 4);
        n_read++;
      end
      rv32_pkg::CMD_RESET: begin
        hart_clear();
        n_reset++;
      end
      default: begin
        n_exec++;
        if (!halted) begin
          if (pc[1:0] != 2'b00) stop_hart(rv32_pkg::CAUSE_PC_MIS);
          else begin
            retired++;
            retire_insn(get_bytes(pc, 4), wrote, rd, val);
          end
        end
      end
    endcase
    e.program_counter = pc;
    e.halted = halted;
    e.halt_cause = cause;
    e.retired_count = retired;
    e.dest_valid = wrote;
    e.dest_index = wrote ? rd : 5'd0;
    e.dest_value = wrote ? val : 32'd0;
    pending_results.push_back(e);
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task check_result(rv32_pkg::out_item_t r);
    rv32_pkg::out_item_t e;
    if (pending_results.size() == 0) begin
      report("unexpected result, pc", r.program_counter, 32'h0);
      return;
    end
    e = pending_results.pop_front();
    if (r.program_counter !== e.program_counter)
      report("program_counter", r.program_counter, e.program_counter);
    if (r.halted !== e.halted) report("halted", 32'(r.halted), 32'(e.halted));
    if (r.halt_cause !== e.halt_cause)
      report("halt_cause", 32'(r.halt_cause), 32'(e.halt_cause));
    if (r.read_word !== e.read_word) report("read_word", r.read_word, e.read_word);
    if (r.retired_count !== e.retired_count)
      report("retired_count", r.retired_count, e.retired_count);
    if (r.dest_valid !== e.dest_valid)
      report("dest_valid", 32'(r.dest_valid), 32'(e.dest_valid));
    if (r.dest_index !== e.dest_index)
      report("dest_index", 32'(r.dest_index), 32'(e.dest_index));
    if (r.dest_value !== e.dest_value) report("dest_value", r.dest_value, e.dest_value);
  endtask
endclass

module testbench;
  import rv32_pkg::*;

  localparam int IdleLimit = 3000;

  logic clk_i, rst_ni, start, busy, done;
  in_item_t  item_i;
  out_item_t result_o;
  hart_scoreboard sb;
  bit burst;
  int idle_cycles;

  rv32i_instruction_executor_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .item_i(item_i), .done(done), .result_o(result_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result check and watchdog; both see pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done) sb.check_result(result_o);
      if (done || (start && !busy)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", IdleLimit);
        $display("testbench failed");
        $finish;
      end
    end
  end

  function automatic logic [31:0] enc_i(logic [6:0] op, logic [4:0] rd, logic [2:0] f3,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [2:0] f3, logic [4:0] rs1, logic [4:0] rs2,
                                        logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [4:0] rd, logic [20:0] imm);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // one command through the start/busy handshake; start stays high across back-to-back items
  task send(cmd_e cmd, logic [15:0] addr, logic [31:0] word);
    int gap;
    if ($urandom_range(0, 39) == 0) burst = !burst;
    gap = burst ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    item_i <= '{opcode: cmd, mem_address: addr, write_word: word};
    do @(posedge clk_i); while (busy);
    sb.note_command('{opcode: cmd, mem_address: addr, write_word: word});
  endtask

  // place an instruction at the pc if it lies in memory and the hart runs, then execute it
  task run_insn(logic [31:0] insn);
    if (sb.pc < MemBytes && !sb.halted) send(CMD_WRITE, sb.pc[15:0], insn);
    send(CMD_EXEC, 16'($urandom()), $urandom());
  endtask

  function automatic logic [31:0] random_insn();
    logic [4:0] rd, rs1, rs2;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [11:0] imm;
    logic [31:0] raw;
    int k;
    rd = 5'($urandom_range(0, 31));
    rs1 = 5'($urandom_range(0, 31));
    rs2 = 5'($urandom_range(0, 31));
    f3 = 3'($urandom_range(0, 7));
    f7 = ($urandom_range(0, 9) == 0) ? 7'($urandom()) : ($urandom_range(0, 1) ? 7'h20 : 7'h00);
    imm = 12'($urandom());
    k = $urandom_range(0, 99);
    if (k < 8) return {20'($urandom()), rd, OP_LUI};
    if (k < 12) return {20'($urandom()), rd, OP_AUIPC};
    if (k < 17) begin
      if ($urandom_range(0, 9) == 0) return enc_j(rd, 21'($urandom()));
      return enc_j(rd, 21'($signed($urandom_range(0, 32)) - 16) << 2);
    end
    if (k < 21) begin
      if ($urandom_range(0, 1)) return enc_i(OP_JALR, rd, 3'd0, 5'd0, 12'($urandom_range(0, 255) << 2));
      return enc_i(OP_JALR, rd, ($urandom_range(0, 5) == 0) ? f3 : 3'd0, rs1, imm);
    end
    if (k < 31) return enc_b(f3, rs1, rs2, 13'($signed($urandom_range(0, 32)) - 16) << 2);
    if (k < 45) begin
      // keep loads on written bytes or outside memory
      for (int t = 0; t < 8; t++) begin
        if (sb.bytes_known(sb.regs[rs1] + {{20{imm[11]}}, imm}, 4))
          return enc_i(OP_LOAD, rd, f3, rs1, imm);
        rs1 = 5'($urandom_range(0, 31));
        imm = 12'($urandom());
      end
      return enc_i(OP_LOAD, rd, f3, 5'd0, 12'($urandom_range(0, 1020)));
    end
    if (k < 53) begin
      if ($urandom_range(0, 1)) return enc_s(f3, 5'd0, rs2, 12'($urandom_range(0, 1023)));
      return enc_s(f3, rs1, rs2, imm);
    end
    if (k < 75) return enc_i(OP_IMM, rd, f3, rs1, (f3 == 3'd1 || f3 == 3'd5) ?
                             {f7, imm[4:0]} : imm);
    if (k < 95) return enc_r(f7, rs2, rs1, f3, rd);
    if (k < 97) return ($urandom_range(0, 1)) ? InsnEcall : InsnEbreak;
    if (k < 99) return {imm, rs1, f3, rd, OP_SYSTEM};
    raw = $urandom();
    // a raw word that decodes as a load must not touch unwritten bytes
    if (raw[6:0] == OP_LOAD &&
        !sb.bytes_known(sb.regs[raw[19:15]] + {{20{raw[31]}}, raw[31:20]}, 4))
      return enc_i(OP_LOAD, rd, f3, 5'd0, 12'($urandom_range(0, 1020)));
    return raw;
  endfunction

  initial begin
    logic [15:0] raddr;
    int k;
    sb = new();
    sb.hart_clear();
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    burst = 1'b0;
    idle_cycles = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // low kilobyte holds code and data
    for (int a = 0; a < 1024; a += 4) send(CMD_WRITE, 16'(a), $urandom());

    // directed: memory top edge, LUI, ALU ops, JAL and the ecall, ebreak, CSR and misaligned-pc halts
    send(CMD_WRITE, 16'hfffc, 32'hffff_ffff);
    send(CMD_WRITE, 16'hffff, 32'h8000_0000);
    send(CMD_READ, 16'hffff, 32'h0);
    send(CMD_READ, 16'hfffc, 32'hffff_ffff);
    run_insn({20'h80000, 5'd1, OP_LUI});
    run_insn(enc_i(OP_IMM, 5'd2, 3'd0, 5'd0, 12'hfff));
    run_insn(enc_r(7'h20, 5'd2, 5'd1, 3'd5, 5'd3));
    run_insn(enc_r(7'h20, 5'd2, 5'd1, 3'd0, 5'd4));
    run_insn(enc_i(OP_IMM, 5'd5, 3'd1, 5'd1, 12'h040));
    send(CMD_EXEC, 16'h0, 32'h0);
    send(CMD_RESET, 16'h0, 32'h0);
    run_insn(InsnEcall);
    send(CMD_RESET, 16'h0, 32'h0);
    run_insn(InsnEbreak);
    send(CMD_RESET, 16'h0, 32'h0);
    run_insn(enc_i(OP_SYSTEM, 5'd1, 3'd1, 5'd0, 12'h300));
    send(CMD_RESET, 16'h0, 32'h0);
    run_insn(enc_j(5'd1, 21'd2));
    send(CMD_EXEC, 16'h0, 32'h0);
    send(CMD_RESET, 16'h0, 32'h0);

    while (sb.n_write + sb.n_read + sb.n_exec + sb.n_reset < 700) begin
      k = $urandom_range(0, 99);
      if (sb.halted && k < 70) send(CMD_RESET, 16'($urandom()), $urandom());
      else if (k < 5) send(CMD_WRITE, 16'($urandom()), $urandom());
      else if (k < 12) begin
        raddr = 16'($urandom());
        for (int t = 0; t < 16 && !sb.bytes_known({16'b0, raddr}, 4); t++)
          raddr = 16'($urandom());
        if (!sb.bytes_known({16'b0, raddr}, 4)) raddr = 16'($urandom_range(0, 1020));
        send(CMD_READ, raddr, $urandom());
      end else if (k < 14) send(CMD_RESET, 16'($urandom()), $urandom());
      else run_insn(random_insn());
    end
    start <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d writes, %0d reads, %0d executes, %0d hart resets",
             sb.n_write, sb.n_read, sb.n_exec, sb.n_reset);
    $display("%0d halts taken, %0d mismatches", sb.n_halt, sb.errors);
    if (sb.errors == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end
endmodule

/* sim.f */
src/rv32_pkg.sv
src/rv32_datapath.sv
src/rv32_ctrl.sv
src/rv32i_instruction_executor_unit.sv
sim/testbench.sv
